FILE: hdl/bsr_pkg.sv
`timescale 1ns / 1ps

package bsr_pkg;

    // Built depth of the stack by default, and the width of the capacity register.
    localparam int DEPTH_DEFAULT = 32;
    localparam int CAP_W         = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Operation codes carried by a command.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_DUP   = 3'd3;
    localparam logic [2:0] OP_ROTU  = 3'd4;
    localparam logic [2:0] OP_ROTD  = 3'd5;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ROT   = 2'd3;

    // Jobs handed to the storage engine.
    localparam logic [2:0] JOB_NONE  = 3'd0;
    localparam logic [2:0] JOB_WRITE = 3'd1;
    localparam logic [2:0] JOB_READ  = 3'd2;
    localparam logic [2:0] JOB_DUP   = 3'd3;
    localparam logic [2:0] JOB_ROT   = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [7:0]       push_byte;
        logic [CAP_W-1:0] rotate_count;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic [1:0]       status;
        logic [CAP_W-1:0] fill;
    } result_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       desc;   // rotate walks from high addresses to low ones
        logic [7:0] data;
    } job_t;

endpackage

FILE: hdl/bsr_engine.sv
`timescale 1ns / 1ps

module bsr_engine #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  bsr_pkg::job_t      job,
    input  logic [AW-1:0]      first_addr,
    input  logic [AW-1:0]      last_addr,
    output logic               done,
    output logic [7:0]         rdata
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RD_WAIT = 2'd1;
    localparam logic [1:0] S_ROT_RUN = 2'd2;
    localparam logic [1:0] S_ROT_END = 2'd3;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_q;

    logic [1:0]    state_reg, state_next;
    logic          done_reg, done_next;
    logic [7:0]    rdata_reg, rdata_next;
    logic [2:0]    kind_reg, kind_next;
    logic          desc_reg, desc_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] last_reg, last_next;
    logic [7:0]    moved_reg, moved_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] ptr_step;
    logic [AW-1:0] ptr_back;

    assign ptr_step = desc_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
    assign ptr_back = desc_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rdata_next = rdata_reg;
        kind_next  = kind_reg;
        desc_next  = desc_reg;
        ptr_next   = ptr_reg;
        last_next  = last_reg;
        moved_next = moved_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_q;

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    kind_next  = job.kind;
                    desc_next  = job.desc;
                    ptr_next   = first_addr;
                    last_next  = last_addr;
                    rdata_next = 8'd0;
                    case (job.kind)
                        bsr_pkg::JOB_NONE:
                        begin
                            done_next = 1'b1;
                        end
                        bsr_pkg::JOB_WRITE:
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = first_addr;
                            wr_data   = job.data;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = first_addr;
                            state_next = S_RD_WAIT;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                case (kind_reg)
                    bsr_pkg::JOB_READ:
                    begin
                        rdata_next = rd_q;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    bsr_pkg::JOB_DUP:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = last_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        // The entry that travels to the far end is held aside.
                        moved_next = rd_q;
                        rd_en      = 1'b1;
                        rd_addr    = ptr_step;
                        ptr_next   = ptr_step;
                        state_next = S_ROT_RUN;
                    end
                endcase
            end
            S_ROT_RUN:
            begin
                // rd_q holds the entry at ptr; it shifts one place toward the start.
                wr_en   = 1'b1;
                wr_addr = ptr_back;
                if (ptr_reg == last_reg)
                begin
                    state_next = S_ROT_END;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_step;
                    ptr_next = ptr_step;
                end
            end
            S_ROT_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = last_reg;
                wr_data    = moved_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        kind_reg  <= kind_next;
        desc_reg  <= desc_next;
        ptr_reg   <= ptr_next;
        last_reg  <= last_next;
        moved_reg <= moved_next;
    end

    assign done  = done_reg;
    assign rdata = rdata_reg;

endmodule

FILE: hdl/byte_stack_with_rotate_unit.sv
`timescale 1ns / 1ps

// Byte-wide LIFO stack with push, pop, peek, dup and two rotates.
// A command is taken on a rising edge with start high and busy low. Exactly
// one result follows for every command; it sits on the result port for one
// cycle with done high and must be taken then, since the receiver cannot
// hold it off. Busy drops in the cycle that done is high, so the next
// command may be started in that same cycle.
// Counted from the transfer edge, done comes in the cycle after it for push,
// for the unused codes, for a rotate over fewer than two entries and for every
// refused command; pop, peek and dup first read the entry memory, and a rotate
// reads, shifts and writes its window one entry per cycle through the single
// read and single write port of the entry memory, so the rotate length sets
// the time a command holds the block. The capacity register is written on the
// cfg channel, which is always ready; the user must write it only while no
// command is in flight, as the block itself does not enforce this. Reset
// empties the stack and sets the capacity to 32. The entry memory is not
// cleared; entries at or above the fill level are never read.
module byte_stack_with_rotate_unit #(
    parameter int DEPTH = bsr_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bsr_pkg::cmd_t                cmd,
    output logic                         done,
    output bsr_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bsr_pkg::CAP_W-1:0]    cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > bsr_pkg::CAP_W) ? CW : bsr_pkg::CAP_W;

    logic [bsr_pkg::CAP_W-1:0] capacity_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic                      busy_reg;
    logic [1:0]                status_reg, status_next;
    logic [bsr_pkg::CAP_W-1:0] fill_reg;

    logic          accept;
    logic [XW-1:0] cap_x;
    logic [XW-1:0] capacity_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] n_x;
    logic          full;
    logic          empty;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] low_addr;
    logic [AW-1:0] end_addr;

    bsr_pkg::job_t job;
    logic [AW-1:0] first_addr;
    logic [AW-1:0] last_addr;
    logic          eng_done;
    logic [7:0]    eng_rdata;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign busy      = busy_reg && !eng_done;

    assign capacity_x = XW'(capacity_reg);
    assign count_x    = XW'(count_reg);
    assign n_x        = XW'(cmd.rotate_count);

    always_comb
    begin
        if (capacity_x == XW'(0))
        begin
            cap_x = XW'(1);
        end
        else if (capacity_x > XW'(DEPTH))
        begin
            cap_x = XW'(DEPTH);
        end
        else
        begin
            cap_x = capacity_x;
        end
    end

    // A lowered capacity below the fill level also counts as full.
    assign full     = count_x >= cap_x;
    assign empty    = count_reg == CW'(0);
    assign top_addr = AW'(count_x - XW'(1));
    assign low_addr = AW'(count_x - n_x);
    assign end_addr = AW'(count_x);

    always_comb
    begin
        count_next  = count_reg;
        status_next = bsr_pkg::ST_OK;
        job.kind    = bsr_pkg::JOB_NONE;
        job.desc    = 1'b0;
        job.data    = cmd.push_byte;
        first_addr  = top_addr;
        last_addr   = end_addr;

        case (cmd.op)
            bsr_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_next = bsr_pkg::ST_FULL;
                end
                else
                begin
                    job.kind   = bsr_pkg::JOB_WRITE;
                    first_addr = end_addr;
                    count_next = count_reg + CW'(1);
                end
            end
            bsr_pkg::OP_POP, bsr_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = bsr_pkg::ST_EMPTY;
                end
                else
                begin
                    job.kind = bsr_pkg::JOB_READ;
                    if (cmd.op == bsr_pkg::OP_POP)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            bsr_pkg::OP_DUP:
            begin
                if (empty)
                begin
                    status_next = bsr_pkg::ST_EMPTY;
                end
                else if (full)
                begin
                    status_next = bsr_pkg::ST_FULL;
                end
                else
                begin
                    job.kind   = bsr_pkg::JOB_DUP;
                    count_next = count_reg + CW'(1);
                end
            end
            bsr_pkg::OP_ROTU, bsr_pkg::OP_ROTD:
            begin
                if (n_x > count_x)
                begin
                    status_next = bsr_pkg::ST_ROT;
                end
                else if (n_x >= XW'(2))
                begin
                    job.kind = bsr_pkg::JOB_ROT;
                    if (cmd.op == bsr_pkg::OP_ROTU)
                    begin
                        // The top entry sinks to the low end of the window.
                        job.desc   = 1'b1;
                        first_addr = top_addr;
                        last_addr  = low_addr;
                    end
                    else
                    begin
                        first_addr = low_addr;
                        last_addr  = top_addr;
                    end
                end
            end
            default:
            begin
                status_next = bsr_pkg::ST_OK;
            end
        endcase
    end

    bsr_engine #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (accept),
        .job        (job),
        .first_addr (first_addr),
        .last_addr  (last_addr),
        .done       (eng_done),
        .rdata      (eng_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bsr_pkg::CAP_RESET;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end
            else if (eng_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            fill_reg   <= bsr_pkg::CAP_W'(count_next);
        end
    end

    assign done             = eng_done;
    assign result.read_byte = eng_rdata;
    assign result.status    = status_reg;
    assign result.fill      = fill_reg;

    // Every result belongs to a command that was accepted and not yet answered.
    assert property (@(posedge clk) disable iff (!rst_n) eng_done |-> busy_reg)
        else $error("result without a pending command");

    // An accepted command raises busy_reg in the cycle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy_reg)
        else $error("accepted command did not raise busy");

    // The fill level never passes the built depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_x <= XW'(DEPTH))
        else $error("fill level beyond the built depth");

    // Refused commands never return data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != bsr_pkg::ST_OK) |-> (result.read_byte == 8'd0))
        else $error("data returned with a failing status");

endmodule

FILE: sim/stack_result_checker.sv
`timescale 1ns / 1ps

module stack_result_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  bsr_pkg::cmd_t             cmd,
    input  logic                      done,
    input  bsr_pkg::result_t          result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [bsr_pkg::CAP_W-1:0] cfg_data,
    output int                        outstanding,
    output int                        mismatches
);

    localparam int DEPTH = bsr_pkg::DEPTH_DEFAULT;

    logic [7:0]                stack_mem [DEPTH];
    int                        stack_level;
    logic [bsr_pkg::CAP_W-1:0] cap_reg;
    bsr_pkg::result_t          expected_results[$];
    int                        err_count;

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic apply_cmd(input bsr_pkg::cmd_t c, output bsr_pkg::result_t r);
        int   lim;
        int   n;
        int   top_i;
        int   low_i;
        logic [7:0] moved;
        lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        n = c.rotate_count;
        r = '0;
        r.status = bsr_pkg::ST_OK;
        case (c.op)
            bsr_pkg::OP_PUSH:
            begin
                if (stack_level >= lim) begin
                    r.status = bsr_pkg::ST_FULL;
                end else begin
                    stack_mem[stack_level] = c.push_byte;
                    stack_level++;
                end
            end
            bsr_pkg::OP_POP, bsr_pkg::OP_PEEK:
            begin
                if (stack_level == 0) begin
                    r.status = bsr_pkg::ST_EMPTY;
                end else begin
                    r.read_byte = stack_mem[stack_level-1];
                    if (c.op == bsr_pkg::OP_POP)
                        stack_level--;
                end
            end
            bsr_pkg::OP_DUP:
            begin
                if (stack_level == 0) begin
                    r.status = bsr_pkg::ST_EMPTY;
                end else if (stack_level >= lim) begin
                    r.status = bsr_pkg::ST_FULL;
                end else begin
                    stack_mem[stack_level] = stack_mem[stack_level-1];
                    stack_level++;
                end
            end
            bsr_pkg::OP_ROTU, bsr_pkg::OP_ROTD:
            begin
                if (n > stack_level) begin
                    r.status = bsr_pkg::ST_ROT;
                end else if (n >= 2) begin
                    top_i = stack_level - 1;
                    low_i = stack_level - n;
                    if (c.op == bsr_pkg::OP_ROTU) begin
                        moved = stack_mem[top_i];
                        for (int i = top_i; i > low_i; i--)
                            stack_mem[i] = stack_mem[i-1];
                        stack_mem[low_i] = moved;
                    end else begin
                        moved = stack_mem[low_i];
                        for (int i = low_i; i < top_i; i++)
                            stack_mem[i] = stack_mem[i+1];
                        stack_mem[top_i] = moved;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.fill = stack_level[bsr_pkg::CAP_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bsr_pkg::result_t exp_r;
        bsr_pkg::result_t new_r;
        if (!rst_n) begin
            expected_results.delete();
            stack_level = 0;
            cap_reg     = bsr_pkg::CAP_RESET;
            err_count   = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end else begin
            // The result of one command and the transfer of the next can share an edge.
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, result);
                    err_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("read_byte", exp_r.read_byte, result.read_byte);
                    compare_field("status", exp_r.status, result.status);
                    compare_field("fill", exp_r.fill, result.fill);
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (start && !busy) begin
                apply_cmd(cmd, new_r);
                expected_results.push_back(new_r);
            end
            outstanding <= expected_results.size();
            mismatches  <= err_count;
        end
    end

endmodule

FILE: sim/byte_stack_with_rotate_unit_tb.sv
`timescale 1ns / 1ps

module byte_stack_with_rotate_unit_tb;

    localparam logic [2:0] OP_RSVD_LO     = 3'd6;
    localparam logic [2:0] OP_RSVD_HI     = 3'd7;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         MAX_GAP        = 30;
    localparam int         SEG_ITEMS      = 130;
    localparam int         SEGS_PER_PHASE = 5;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    bsr_pkg::cmd_t             cmd;
    logic                      done;
    bsr_pkg::result_t          result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [bsr_pkg::CAP_W-1:0] cfg_data;

    int outstanding;
    int mismatches;
    int idle_pct;
    int stall_cycles = 0;

    int cap_plan [3*SEGS_PER_PHASE] = '{32, 2, 0, 63, 17,
                                        1, 33, 9, 32, 5,
                                        63, 0, 24, 3, 32};

    byte_stack_with_rotate_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stack_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bsr_pkg::cmd_t make_cmd(logic [2:0] op, logic [7:0] b,
                                               logic [bsr_pkg::CAP_W-1:0] n);
        bsr_pkg::cmd_t c;
        c.op           = op;
        c.push_byte    = b;
        c.rotate_count = n;
        return c;
    endfunction

    // Stage 0 leans toward filling the stack, stage 2 toward emptying it.
    function automatic bsr_pkg::cmd_t random_cmd(int stage);
        bsr_pkg::cmd_t c;
        int   p;
        int   push_w;
        int   pop_w;
        c.push_byte    = 8'($urandom_range(255));
        c.rotate_count = ($urandom_range(99) < 85) ? 6'($urandom_range(32))
                                                   : 6'($urandom_range(63, 33));
        if ($urandom_range(99) < 4) begin
            c.op = 3'($urandom_range(7));
            c.rotate_count = 6'($urandom_range(63));
            return c;
        end
        push_w = (stage == 0) ? 55 : ((stage == 1) ? 25 : 10);
        pop_w  = (stage == 0) ? 8 : ((stage == 1) ? 20 : 45);
        p = $urandom_range(99);
        if (p < push_w)
            c.op = bsr_pkg::OP_PUSH;
        else if (p < push_w + pop_w)
            c.op = bsr_pkg::OP_POP;
        else if (p < push_w + pop_w + 8)
            c.op = bsr_pkg::OP_PEEK;
        else if (p < push_w + pop_w + 16)
            c.op = bsr_pkg::OP_DUP;
        else
            c.op = $urandom_range(1) ? bsr_pkg::OP_ROTU : bsr_pkg::OP_ROTD;
        return c;
    endfunction

    // Holds the command until its transfer, then idles the sender at random.
    task automatic run_item(bsr_pkg::cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [bsr_pkg::CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        start        = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        idle_pct     = 36;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty stack, then a few entries with the rotate corner cases.
        run_item(make_cmd(bsr_pkg::OP_POP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_PEEK, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_DUP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_ROTU, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_ROTD, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_ROTU, 8'h00, 6'd1));
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'hFF, 6'd63));
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'hA5, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_DUP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_PEEK, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_ROTU, 8'h00, 6'd4));
        run_item(make_cmd(bsr_pkg::OP_ROTD, 8'h00, 6'd4));
        run_item(make_cmd(bsr_pkg::OP_ROTU, 8'h00, 6'd5));
        run_item(make_cmd(bsr_pkg::OP_ROTD, 8'hFF, 6'd63));
        run_item(make_cmd(bsr_pkg::OP_ROTD, 8'h00, 6'd1));
        run_item(make_cmd(bsr_pkg::OP_ROTU, 8'h00, 6'd2));
        run_item(make_cmd(OP_RSVD_LO, 8'hFF, 6'd63));
        run_item(make_cmd(OP_RSVD_HI, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_POP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_POP, 8'h00, 6'd0));

        // A capacity of zero acts as one, which is now below the fill of two.
        drain();
        write_capacity(6'd0);
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'h3C, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_DUP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_ROTD, 8'h00, 6'd2));
        run_item(make_cmd(bsr_pkg::OP_POP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_POP, 8'h00, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'h5A, 6'd0));
        run_item(make_cmd(bsr_pkg::OP_PUSH, 8'hC3, 6'd0));

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 36 : ((phase == 1) ? 82 : 0);
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
                drain();
                write_capacity(6'(cap_plan[phase*SEGS_PER_PHASE + seg]));
                for (int i = 0; i < SEG_ITEMS; i++)
                    run_item(random_cmd(i * 3 / SEG_ITEMS));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
